// File: sv/assert_macros.svh
// Assertion macros used by the RTL file of the sorted child array node.
// Standalone header; expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: sv/saca_pkg.sv
// Types and codes for the sorted child array node: request and response words,
// per-cell flag and select groups. No dependencies.
package saca_pkg;

  typedef enum logic [1:0] {
    MODE_FIND   = 2'd0,
    MODE_LBOUND = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_DELETE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  localparam int unsigned KeyBits   = 8;
  localparam int unsigned WordHBits = 48;
  localparam int unsigned SlotBits  = 4;
  localparam int unsigned CountBits = 5;

  typedef struct packed {
    mode_e                mode;
    logic [KeyBits-1:0]   key;
    logic [WordHBits-1:0] child_handle;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [SlotBits-1:0]  slot_index;
    logic [WordHBits-1:0] found_handle;
    logic [CountBits-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic valid;
    logic eq;
    logic ge;
    logic le;
  } cell_flags_t;

  typedef struct packed {
    logic first_eq;
    logic first_ge;
    logic ins_slot;
  } cell_sel_t;

endpackage

// File: sv/saca_cell.sv
// One slot of the sorted child array: key, handle and valid bit, local compare
// against the broadcast key, shift from either neighbor. Depends on saca_pkg.
module saca_cell #(
  parameter int unsigned HANDLE_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  saca_pkg::mode_e               mode_i,
  input  logic [saca_pkg::KeyBits-1:0]  key_i,
  input  logic [HANDLE_BITS-1:0]        handle_i,
  input  logic                          ins_ok_i,
  input  logic                          del_hit_i,
  input  saca_pkg::cell_flags_t         left_flags_i,
  input  logic [saca_pkg::KeyBits-1:0]  left_key_i,
  input  logic [HANDLE_BITS-1:0]        left_handle_i,
  input  logic                          right_valid_i,
  input  logic [saca_pkg::KeyBits-1:0]  right_key_i,
  input  logic [HANDLE_BITS-1:0]        right_handle_i,
  output saca_pkg::cell_flags_t         flags_o,
  output saca_pkg::cell_sel_t           sel_o,
  output logic [saca_pkg::KeyBits-1:0]  key_o,
  output logic [HANDLE_BITS-1:0]        handle_o
);
  import saca_pkg::*;

  logic               valid_q, valid_d;
  logic [KeyBits-1:0] key_q, key_d;
  logic [HANDLE_BITS-1:0] handle_q, handle_d;
  cell_flags_t        flags;
  cell_sel_t          sel;

  always_comb begin
    flags.valid = valid_q;
    flags.eq    = valid_q && (key_q == key_i);
    flags.ge    = valid_q && (key_q >= key_i);
    flags.le    = valid_q && (key_q <= key_i);
    sel.first_eq = flags.eq && !left_flags_i.eq;
    sel.first_ge = flags.ge && !left_flags_i.ge;
    sel.ins_slot = !flags.le && left_flags_i.le;
  end

  always_comb begin
    valid_d  = valid_q;
    key_d    = key_q;
    handle_d = handle_q;
    if (en_i) begin
      case (mode_i)
        MODE_INSERT: begin
          if (ins_ok_i) begin
            if (sel.ins_slot) begin
              valid_d  = 1'b1;
              key_d    = key_i;
              handle_d = handle_i;
            end else if (!flags.le && !left_flags_i.le) begin
              valid_d  = left_flags_i.valid;
              key_d    = left_key_i;
              handle_d = left_handle_i;
            end
          end
        end
        MODE_DELETE: begin
          if (del_hit_i && flags.ge) begin
            valid_d  = right_valid_i;
            key_d    = right_key_i;
            handle_d = right_handle_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
  end

  assign flags_o  = flags;
  assign sel_o    = sel;
  assign key_o    = key_q;
  assign handle_o = handle_q;

endmodule

// File: sv/sorted_child_array_node.sv
// Sorted child array node: a row of CAPACITY cells kept in ascending key order.
// The response word is registered and strobes in the cycle after the request word is taken.
// Throughput: one request word per cycle while busy_o is low; every cell compares and shifts as the word is taken.
// Reset: asynchronous, active low; empties the table, busy_o is high for one cycle after.
// Results cannot be stalled; each response word is valid for exactly one cycle.
// Depends on saca_pkg, saca_cell and assert_macros.svh.
`include "assert_macros.svh"

module sorted_child_array_node #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned HANDLE_BITS = 48
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  saca_pkg::req_t req_i,
  output logic           rsp_valid_o,
  output saca_pkg::rsp_t rsp_o
);
  import saca_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = $clog2(CAPACITY);

  logic                   busy_q;
  logic [CW-1:0]          count_q, count_d;
  logic                   rsp_valid_q;
  rsp_t                   rsp_q, rsp_d;

  logic                   accept;
  logic                   ins_take;
  logic [63:0]            h_req_wide;
  logic [HANDLE_BITS-1:0] h_req;

  cell_flags_t            flags  [CAPACITY];
  cell_sel_t              sel    [CAPACITY];
  logic [KeyBits-1:0]     keys   [CAPACITY];
  logic [HANDLE_BITS-1:0] hands  [CAPACITY];
  logic [CAPACITY-1:0]    valid_vec;
  logic [CAPACITY-1:0]    ins_vec;

  logic                   full, hit_eq, hit_ge;
  logic [SW-1:0]          idx_eq, idx_ge, idx_ins;
  logic [HANDLE_BITS-1:0] h_eq, h_ge;
  logic [31:0]            idx_sel_wide, count_wide;
  logic [63:0]            h_sel_wide;
  logic [SW-1:0]          idx_sel;
  logic [HANDLE_BITS-1:0] h_sel;

  localparam cell_flags_t EdgeLeft = '{valid: 1'b1, eq: 1'b0, ge: 1'b0, le: 1'b1};

  assign accept     = start_i && !busy_q;
  assign ins_take   = accept && (req_i.mode == MODE_INSERT) && !full;
  assign h_req_wide = 64'(req_i.child_handle);
  assign h_req      = h_req_wide[HANDLE_BITS-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_flags_t            lf;
    logic [KeyBits-1:0]     lk, rk;
    logic [HANDLE_BITS-1:0] lh, rh;
    logic                   rv;

    if (i == 0) begin : g_left_edge
      assign lf = EdgeLeft;
      assign lk = '0;
      assign lh = '0;
    end else begin : g_left
      assign lf = flags[i-1];
      assign lk = keys[i-1];
      assign lh = hands[i-1];
    end

    if (i == CAPACITY - 1) begin : g_right_edge
      assign rv = 1'b0;
      assign rk = '0;
      assign rh = '0;
    end else begin : g_right
      assign rv = flags[i+1].valid;
      assign rk = keys[i+1];
      assign rh = hands[i+1];
    end

    saca_cell #(
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .en_i           (accept),
      .mode_i         (req_i.mode),
      .key_i          (req_i.key),
      .handle_i       (h_req),
      .ins_ok_i       (!full),
      .del_hit_i      (hit_eq),
      .left_flags_i   (lf),
      .left_key_i     (lk),
      .left_handle_i  (lh),
      .right_valid_i  (rv),
      .right_key_i    (rk),
      .right_handle_i (rh),
      .flags_o        (flags[i]),
      .sel_o          (sel[i]),
      .key_o          (keys[i]),
      .handle_o       (hands[i])
    );

    assign valid_vec[i] = flags[i].valid;
    assign ins_vec[i]   = sel[i].ins_slot;
  end

  assign full = flags[CAPACITY-1].valid;

  always_comb begin
    hit_eq  = 1'b0;
    hit_ge  = 1'b0;
    idx_eq  = '0;
    idx_ge  = '0;
    idx_ins = '0;
    h_eq    = '0;
    h_ge    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_eq  = hit_eq | sel[i].first_eq;
      hit_ge  = hit_ge | sel[i].first_ge;
      idx_eq  = idx_eq  | (sel[i].first_eq ? SW'(i) : '0);
      idx_ge  = idx_ge  | (sel[i].first_ge ? SW'(i) : '0);
      idx_ins = idx_ins | (sel[i].ins_slot ? SW'(i) : '0);
      h_eq    = h_eq | (sel[i].first_eq ? hands[i] : '0);
      h_ge    = h_ge | (sel[i].first_ge ? hands[i] : '0);
    end
  end

  always_comb begin
    count_d = count_q;
    rsp_d   = '0;
    idx_sel = '0;
    h_sel   = '0;
    rsp_d.status = ST_OK;
    case (req_i.mode)
      MODE_FIND: begin
        if (hit_eq) begin
          idx_sel = idx_eq;
          h_sel   = h_eq;
        end else begin
          rsp_d.status = ST_MISS;
        end
      end
      MODE_LBOUND: begin
        if (hit_ge) begin
          idx_sel = idx_ge;
          h_sel   = h_ge;
        end else begin
          rsp_d.status = ST_MISS;
        end
      end
      MODE_INSERT: begin
        if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          idx_sel = idx_ins;
          count_d = count_q + CW'(1);
        end
      end
      MODE_DELETE: begin
        if (hit_eq) begin
          idx_sel = idx_eq;
          h_sel   = h_eq;
          count_d = count_q - CW'(1);
        end else begin
          rsp_d.status = ST_MISS;
        end
      end
      default: begin
      end
    endcase
    idx_sel_wide       = 32'(idx_sel);
    h_sel_wide         = 64'(h_sel);
    count_wide         = 32'(count_d);
    rsp_d.slot_index   = idx_sel_wide[SlotBits-1:0];
    rsp_d.found_handle = h_sel_wide[WordHBits-1:0];
    rsp_d.entry_count  = count_wide[CountBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b1;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      busy_q      <= 1'b0;
      rsp_valid_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy_o      = busy_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  `ASSERT_CLK(a_count_matches_cells, clk_i, rst_ni, $countones(valid_vec) == count_q)
  `ASSERT_CLK(a_word_answered, clk_i, rst_ni, accept |=> rsp_valid_o)
  `ASSERT_CLK(a_insert_one_slot, clk_i, rst_ni, ins_take |-> $onehot(ins_vec))
  `ASSERT_CLK(a_insert_grows, clk_i, rst_ni, ins_take |=> (count_q == $past(count_q) + CW'(1)))

endmodule
